// ===== design/ffsd_pkg.sv =====
// Shared constants and types for the fixed-frame sum-checksum deframer.
`default_nettype none

package ffsd_pkg;

	// Default frame length in bytes, header and checksum included.
	localparam int unsigned FrameLenDefault = 67;

	// Header value after reset.
	localparam logic [7:0] HeaderReset = 8'hc8;

	// Field widths.
	localparam int unsigned ByteW  = 8;
	localparam int unsigned IndexW = 7;
	localparam int unsigned CountW = 16;

	typedef logic [ByteW-1:0]  byte_t;
	typedef logic [IndexW-1:0] index_t;
	typedef logic [CountW-1:0] count_t;

	// One result request as it leaves the block.
	typedef struct packed {
		byte_t  byte_out;
		index_t byte_index;
		logic   in_frame;
		logic   frame_end;
		logic   frame_ok;
		count_t header_errors;
		count_t checksum_errors;
	} result_t;

	// Counter increment that sticks at the top value.
	function automatic count_t sat_inc(input count_t v);
		sat_inc = (v == {CountW{1'b1}}) ? v : count_t'(v + count_t'(1));
	endfunction

endpackage

`default_nettype wire

// ===== design/ffsd_if.sv =====
// Valid/ready channel interfaces for received bytes and deframer results.
`default_nettype none

interface ffsd_byte_if;
	import ffsd_pkg::*;
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ffsd_result_if;
	import ffsd_pkg::*;
	logic   valid;
	logic   ready;
	byte_t  byte_out;
	index_t byte_index;
	logic   in_frame;
	logic   frame_end;
	logic   frame_ok;
	count_t header_errors;
	count_t checksum_errors;

	modport source (
		output valid, output byte_out, output byte_index, output in_frame,
		output frame_end, output frame_ok, output header_errors,
		output checksum_errors, input ready
	);
	modport sink (
		input valid, input byte_out, input byte_index, input in_frame,
		input frame_end, input frame_ok, input header_errors,
		input checksum_errors, output ready
	);
endinterface

`default_nettype wire

// ===== design/fixed_frame_sum_checksum_deframer_unit.sv =====
// Top level of the fixed-frame sum-checksum deframer.
//
//  Channel  Dir  Handshake            Payload
//  rx       in   rx.valid/rx.ready    rx_byte
//  frm      out  frm.valid/frm.ready  byte, index, flags, error counters
//  cfg      in   cfg_we               cfg_wdata = header byte
//
// Each byte passes an input register (_s1) and a result register (_s2), one
// request per cycle sustained while frm.ready stays high. The running sum, the
// frame position and the counters update in the single step from _s1 to _s2.
// A stalled result holds both stages; a free result stage lets a new byte in
// on the same cycle. arst_n clears control state and the counters and loads
// the header register with 0xc8.
`default_nettype none

module fixed_frame_sum_checksum_deframer_unit import ffsd_pkg::*; #(
	parameter int unsigned FRAME_LEN = FrameLenDefault
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ffsd_byte_if.sink   rx,
	ffsd_result_if.source frm,
	input  wire logic   cfg_we,
	input  wire byte_t  cfg_wdata
);

	// Compare points of the frame, one bit wider than the index.
	localparam logic [IndexW:0] SumHighPos = (IndexW+1)'(FRAME_LEN - 2);
	localparam logic [IndexW:0] LastPos    = (IndexW+1)'(FRAME_LEN - 1);

	// Header register.
	byte_t header_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HeaderReset;
		end else if (cfg_we) begin
			header_q <= cfg_wdata;
		end
	end

	// Pipeline handshake.
	logic    valid_s1, valid_s2;
	byte_t   byte_s1;
	result_t res_s2;
	logic    adv_s2, adv_s1;

	assign adv_s2   = valid_s1 && (!valid_s2 || frm.ready);
	assign adv_s1   = rx.valid && rx.ready;
	assign rx.ready = !valid_s1 || adv_s2;

	// Frame state.
	logic   reading_q;
	index_t pos_q;
	count_t sum_q;
	byte_t  sum_high_q;
	count_t stray_q;
	count_t bad_q;

	// Next-state and result logic for the byte in the input register.
	logic           hdr_hit;
	logic [IndexW:0] pos_ext;
	logic           is_last;
	logic           sum_good;
	logic           reading_d;
	index_t         pos_d;
	count_t         sum_d;
	count_t         stray_d;
	count_t         bad_d;
	result_t        res_d;

	always_comb begin
		hdr_hit   = !reading_q && (byte_s1 == header_q);
		pos_ext   = {1'b0, pos_q};
		is_last   = reading_q && (pos_ext >= LastPos);
		sum_good  = ({sum_high_q, byte_s1} == sum_q);
		reading_d = reading_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		stray_d   = stray_q;
		bad_d     = bad_q;
		if (!reading_q) begin
			if (hdr_hit) begin
				reading_d = 1'b1;
				pos_d     = index_t'(1);
				sum_d     = count_t'(byte_s1);
			end else begin
				pos_d   = '0;
				stray_d = sat_inc(stray_q);
			end
		end else begin
			if (pos_ext < SumHighPos) begin
				sum_d = count_t'(sum_q + count_t'(byte_s1));
			end
			if (is_last) begin
				reading_d = 1'b0;
				pos_d     = '0;
				if (!sum_good) begin
					bad_d = sat_inc(bad_q);
				end
			end else begin
				pos_d = index_t'(pos_q + index_t'(1));
			end
		end
		res_d.byte_out        = byte_s1;
		res_d.byte_index      = reading_q ? pos_q : '0;
		res_d.in_frame        = reading_q || hdr_hit;
		res_d.frame_end       = is_last;
		res_d.frame_ok        = is_last && sum_good;
		res_d.header_errors   = stray_d;
		res_d.checksum_errors = bad_d;
	end

	// Control state, counters and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			reading_q <= 1'b0;
			pos_q     <= '0;
			sum_q     <= '0;
			stray_q   <= '0;
			bad_q     <= '0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2  <= 1'b1;
				reading_q <= reading_d;
				pos_q     <= pos_d;
				sum_q     <= sum_d;
				stray_q   <= stray_d;
				bad_q     <= bad_d;
			end else if (frm.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			byte_s1 <= rx.rx_byte;
		end
		if (adv_s2) begin
			res_s2 <= res_d;
			if (reading_q && (pos_ext == SumHighPos)) begin
				sum_high_q <= byte_s1;
			end
		end
	end

	// Result port.
	assign frm.valid           = valid_s2;
	assign frm.byte_out        = res_s2.byte_out;
	assign frm.byte_index      = res_s2.byte_index;
	assign frm.in_frame        = res_s2.in_frame;
	assign frm.frame_end       = res_s2.frame_end;
	assign frm.frame_ok        = res_s2.frame_ok;
	assign frm.header_errors   = res_s2.header_errors;
	assign frm.checksum_errors = res_s2.checksum_errors;

	// The frame position never reaches the frame length.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} <= LastPos)
		else $error("frame position out of range");

	// While idle the position is at the start.
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!reading_q |-> pos_q == '0)
		else $error("idle with nonzero position");

	// A frame end or a good frame only comes from a byte inside a frame, and a good frame also marks the frame end.
	a_end_member: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.frame_end || res_s2.frame_ok) |->
		res_s2.in_frame && res_s2.frame_end)
		else $error("frame flags without frame membership");

	// The last byte of a frame leaves the block idle.
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && is_last |=> !reading_q)
		else $error("still reading after frame end");

endmodule

`default_nettype wire
